FILE: rtl/core/gdn_pkg.sv
package gdn_pkg;

  localparam logic [22:0] JDN_MIN     = 23'd1721426;
  localparam logic [22:0] JDN_MAX     = 23'd5373484;
  localparam logic [22:0] JDN_OFS_FWD = 23'd1721119;
  localparam logic [22:0] JDN_OFS_INV = 23'd32044;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [13:0] YEAR_SUBST  = 14'd2000;
  localparam logic [17:0] DAYS_400Y   = 18'd146097;
  localparam logic [10:0] DAYS_4Y     = 11'd1461;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;

  // reciprocal constants, exact or one-low estimates as used
  localparam logic [12:0] REC_100     = 13'd5243;   // >> 19
  localparam logic [14:0] REC_400Y    = 15'd29398;  // >> 32, may be one low
  localparam logic [13:0] REC_4Y      = 14'd11483;  // >> 24, may be one low
  localparam logic [12:0] REC_153     = 13'd6854;   // >> 20, exact here

  typedef struct packed {
    logic        action;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] day_number;
  } gdn_req_t;

  typedef struct packed {
    logic [22:0] jd;
    logic        ok;
  } gdn_jd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] day_number;
    logic [2:0]  weekday;
    logic        ok;
  } gdn_res_t;

  // days before month index mm of a march-based year: (153*mm+2)/5
  function automatic logic [8:0] mday_off(input logic [3:0] mm);
    logic [8:0] v;
    case (mm)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
      4'd2:                                        v = leap ? 5'd29 : 5'd28;
      default:                                     v = 5'd0;
    endcase
    return v;
  endfunction

  // 8 = 1 mod 7, so the octal digit sum keeps the residue
  function automatic logic [2:0] mod7(input logic [22:0] x);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  t;
    w = {1'b0, x};
    s = 6'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(w[3*i +: 3]);
    end
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd14) begin
      t = t - 4'd14;
    end else if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

endpackage

FILE: rtl/core/gdn_date_front.sv
module gdn_date_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gdn_pkg::gdn_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output gdn_pkg::gdn_jd_t  out_jd
);

  logic [2:0] vld_r;
  logic [2:0] rdy;

  // stage 1: check and substitute, clamp day number
  logic        act1_r, ok1_r;
  logic [4:0]  d1_r;
  logic [3:0]  m1_r;
  logic [13:0] y1_r;
  logic [22:0] jdi1_r;
  logic        ok1_nxt;
  logic [4:0]  d1_nxt;
  logic [3:0]  m1_nxt;
  logic [13:0] y1_nxt;
  logic [22:0] jdi1_nxt;

  logic [26:0] yq_prod;
  logic [7:0]  yq;
  logic [6:0]  yrem;
  logic        leap;
  logic        date_ok;
  logic        jd_lo, jd_hi;

  always_comb begin
    yq_prod = 27'(in_req.year) * 27'(gdn_pkg::REC_100);
    yq      = yq_prod[26:19];
    yrem    = 7'(in_req.year - 14'(yq) * 14'd100);
    leap    = (in_req.year[1:0] == 2'd0) && ((yrem != 7'd0) || (yq[1:0] == 2'd0));
    date_ok = (in_req.year != 14'd0) && (in_req.year <= gdn_pkg::YEAR_MAX) &&
              (in_req.month != 4'd0) && (in_req.month <= 4'd12) &&
              (in_req.day != 5'd0) &&
              (in_req.day <= gdn_pkg::month_len(in_req.month, leap));
    jd_lo   = in_req.day_number < gdn_pkg::JDN_MIN;
    jd_hi   = in_req.day_number > gdn_pkg::JDN_MAX;
    d1_nxt  = date_ok ? in_req.day : 5'd1;
    m1_nxt  = date_ok ? in_req.month : 4'd1;
    y1_nxt  = date_ok ? in_req.year : gdn_pkg::YEAR_SUBST;
    jdi1_nxt = jd_lo ? gdn_pkg::JDN_MIN : (jd_hi ? gdn_pkg::JDN_MAX : in_req.day_number);
    ok1_nxt = in_req.action ? !(jd_lo || jd_hi) : date_ok;
  end

  // stage 2: year terms
  logic        act2_r, ok2_r;
  logic [22:0] jdi2_r;
  logic [6:0]  q2_r;
  logic [21:0] part2_r;
  logic        mar;
  logic [13:0] yy;
  logic [3:0]  mm;
  logic [26:0] yy_prod;
  logic [6:0]  q2_nxt;
  logic [21:0] part2_nxt;

  always_comb begin
    mar       = m1_r < 4'd3;
    yy        = y1_r - 14'(mar);
    mm        = mar ? m1_r + 4'd9 : m1_r - 4'd3;
    yy_prod   = 27'(yy) * 27'(gdn_pkg::REC_100);
    q2_nxt    = yy_prod[25:19];
    part2_nxt = 22'(d1_r) + 22'(gdn_pkg::mday_off(mm)) +
                22'(yy) * 22'(gdn_pkg::DAYS_YEAR) + 22'(yy[13:2]);
  end

  // stage 3: day number
  gdn_pkg::gdn_jd_t jd3_r, jd3_nxt;

  always_comb begin
    jd3_nxt.ok = ok2_r;
    jd3_nxt.jd = act2_r ? jdi2_r :
                 23'(part2_r) - 23'(q2_r) + 23'(q2_r[6:2]) + gdn_pkg::JDN_OFS_FWD;
  end

  always_comb begin
    rdy[2] = !vld_r[2] || out_ready;
    rdy[1] = !vld_r[1] || rdy[2];
    rdy[0] = !vld_r[0] || rdy[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 3'b000;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      act1_r <= in_req.action;
      ok1_r  <= ok1_nxt;
      d1_r   <= d1_nxt;
      m1_r   <= m1_nxt;
      y1_r   <= y1_nxt;
      jdi1_r <= jdi1_nxt;
    end
    if (rdy[1]) begin
      act2_r  <= act1_r;
      ok2_r   <= ok1_r;
      jdi2_r  <= jdi1_r;
      q2_r    <= q2_nxt;
      part2_r <= part2_nxt;
    end
    if (rdy[2]) begin
      jd3_r <= jd3_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[2];
  assign out_jd    = jd3_r;

endmodule

FILE: rtl/core/gdn_jdn_back.sv
module gdn_jdn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdn_pkg::gdn_jd_t   in_jd,
  output logic              out_valid,
  input  logic              out_ready,
  output gdn_pkg::gdn_res_t  out_res
);

  logic [5:0] vld_r;
  logic [5:0] rdy;

  // carried along every stage
  logic [22:0] jd1_r, jd2_r, jd3_r, jd4_r, jd5_r;
  logic        ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;
  logic [2:0]  wd1_r, wd2_r, wd3_r, wd4_r, wd5_r;

  // stage 1: 400-year cycle estimate
  logic [24:0] x1_r, x1_nxt;
  logic [7:0]  be1_r, be1_nxt;
  logic [2:0]  wd1_nxt;
  logic [39:0] p1;

  always_comb begin
    x1_nxt  = {in_jd.jd + gdn_pkg::JDN_OFS_INV, 2'b11};
    p1      = 40'(x1_nxt) * 40'(gdn_pkg::REC_400Y);
    be1_nxt = p1[39:32];
    wd1_nxt = gdn_pkg::mod7(in_jd.jd) + 3'd1;
  end

  // stage 2: correct cycle count, day within cycle
  logic [7:0]  b2_r, b2_nxt;
  logic [17:0] x2_r, x2_nxt;
  logic [25:0] p2, r2w;
  logic [18:0] r2;
  logic [17:0] r2c;

  always_comb begin
    p2  = 26'(be1_r) * 26'(gdn_pkg::DAYS_400Y);
    r2w = 26'(x1_r) - p2;
    r2  = r2w[18:0];
    if (r2 >= 19'(gdn_pkg::DAYS_400Y)) begin
      b2_nxt = be1_r + 8'd1;
      r2c    = 18'(r2 - 19'(gdn_pkg::DAYS_400Y));
    end else begin
      b2_nxt = be1_r;
      r2c    = r2[17:0];
    end
    x2_nxt = {r2c[17:2], 2'b11};
  end

  // stage 3: 4-year cycle estimate
  logic [7:0]  b3_r;
  logic [17:0] x3_r;
  logic [6:0]  de3_r, de3_nxt;
  logic [31:0] p3;

  always_comb begin
    p3      = 32'(x2_r) * 32'(gdn_pkg::REC_4Y);
    de3_nxt = p3[30:24];
  end

  // stage 4: correct, day of year
  logic [7:0]  b4_r;
  logic [6:0]  dd4_r, dd4_nxt;
  logic [8:0]  e4_r, e4_nxt;
  logic [17:0] p4;
  logic [11:0] r4, r4c;

  always_comb begin
    p4 = 18'(de3_r) * 18'(gdn_pkg::DAYS_4Y);
    r4 = 12'(x3_r - p4);
    if (r4 >= 12'(gdn_pkg::DAYS_4Y)) begin
      dd4_nxt = de3_r + 7'd1;
      r4c     = r4 - 12'(gdn_pkg::DAYS_4Y);
    end else begin
      dd4_nxt = de3_r;
      r4c     = r4;
    end
    e4_nxt = r4c[10:2];
  end

  // stage 5: month index
  logic [7:0]  b5_r;
  logic [6:0]  dd5_r;
  logic [8:0]  e5_r;
  logic [3:0]  mm5_r, mm5_nxt;
  logic [10:0] x5;
  logic [23:0] p5;

  always_comb begin
    x5      = 11'(e4_r) * 11'd5 + 11'd2;
    p5      = 24'(x5) * 24'(gdn_pkg::REC_153);
    mm5_nxt = p5[23:20];
  end

  // stage 6: assemble the date
  gdn_pkg::gdn_res_t res6_r, res6_nxt;
  logic hi_month;

  always_comb begin
    hi_month            = mm5_r >= 4'd10;
    res6_nxt.day        = 5'(10'(e5_r) - 10'(gdn_pkg::mday_off(mm5_r)) + 10'd1);
    res6_nxt.month      = hi_month ? mm5_r - 4'd9 : mm5_r + 4'd3;
    res6_nxt.year       = 14'(15'(b5_r) * 15'd100 + 15'(dd5_r) + 15'(hi_month) - 15'd4800);
    res6_nxt.day_number = jd5_r;
    res6_nxt.weekday    = wd5_r;
    res6_nxt.ok         = ok5_r;
  end

  always_comb begin
    rdy[5] = !vld_r[5] || out_ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 6'b000000;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      jd1_r <= in_jd.jd;
      ok1_r <= in_jd.ok;
      wd1_r <= wd1_nxt;
      x1_r  <= x1_nxt;
      be1_r <= be1_nxt;
    end
    if (rdy[1]) begin
      jd2_r <= jd1_r;
      ok2_r <= ok1_r;
      wd2_r <= wd1_r;
      b2_r  <= b2_nxt;
      x2_r  <= x2_nxt;
    end
    if (rdy[2]) begin
      jd3_r  <= jd2_r;
      ok3_r  <= ok2_r;
      wd3_r  <= wd2_r;
      b3_r   <= b2_r;
      x3_r   <= x2_r;
      de3_r  <= de3_nxt;
    end
    if (rdy[3]) begin
      jd4_r  <= jd3_r;
      ok4_r  <= ok3_r;
      wd4_r  <= wd3_r;
      b4_r   <= b3_r;
      dd4_r  <= dd4_nxt;
      e4_r   <= e4_nxt;
    end
    if (rdy[4]) begin
      jd5_r  <= jd4_r;
      ok5_r  <= ok4_r;
      wd5_r  <= wd4_r;
      b5_r   <= b4_r;
      dd5_r  <= dd4_r;
      e5_r   <= e4_r;
      mm5_r  <= mm5_nxt;
    end
    if (rdy[5]) begin
      res6_r <= res6_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[5];
  assign out_res   = res6_r;

endmodule

FILE: rtl/core/gregorian_day_number_converter.sv
// gregorian date <-> julian day number converter
//
// input stream: in_tuser selects the request kind, 0 converts the date in
// in_tdata to its day number, 1 converts the day number in in_tdata to a date.
// result stream: one result per request, in request order, carrying the date,
// the day number, the weekday (1 monday .. 7 sunday) and in out_tuser a flag
// that is low when the date was invalid (replaced by 1/1/2000) or the day
// number was out of range (clamped to 1/1/1 or 31/12/9999).
//
// nine register stages: a date front end (check, year terms, day number)
// followed by a date back end (two reciprocal divide steps with correction,
// month index, assembly). one request is taken every cycle unless a stall on
// out_tready has filled the pipeline.
// every stage holds while the stage after it is full and stalled, so a stall
// on out_tready fills the empty stages first and only then drops in_tready;
// nothing is lost or repeated.
// reset (rst_n low, synchronous) empties the pipeline; out_tvalid drops in
// the first cycle after reset.
module gregorian_day_number_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // day, month, year, day_number, zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_day, out_month, out_year, out_day_number, weekday, pad
  output logic        out_tuser   // valid_res
);

  gdn_pkg::gdn_req_t req;
  gdn_pkg::gdn_jd_t  mid_jd;
  gdn_pkg::gdn_res_t res;
  logic              mid_valid;
  logic              mid_ready;

  always_comb begin
    req.action     = in_tuser;
    req.day        = in_tdata[4:0];
    req.month      = in_tdata[8:5];
    req.year       = in_tdata[22:9];
    req.day_number = in_tdata[45:23];
  end

  gdn_date_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_jd    (mid_jd)
  );

  gdn_jdn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_jd     (mid_jd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res.weekday, res.day_number, res.year, res.month, res.day};
  assign out_tuser = res.ok;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.weekday != 3'd0) && (res.weekday <= 3'd7))
    else $error("weekday out of range");

  a_jd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.day_number >= gdn_pkg::JDN_MIN) &&
                   (res.day_number <= gdn_pkg::JDN_MAX))
    else $error("day number outside the calendar range");

  a_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.month != 4'd0) && (res.month <= 4'd12) &&
                   (res.day != 5'd0) && (res.year != 14'd0))
    else $error("malformed result date");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_jd))
    else $error("internal request dropped or changed while stalled");
`endif

endmodule

FILE: verif/gdn_checker.sv
`timescale 1ns / 1ps

package gdn_tb_pkg;

  typedef enum logic {
    DATE_TO_NUMBER = 1'b0,
    NUMBER_TO_DATE = 1'b1
  } gdn_action_e;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

endpackage

module gdn_checker
  import gdn_pkg::*;
  import gdn_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen,
  output int          flagged_seen
);

  gdn_res_t expected_results[$];

  function automatic int unsigned date_to_day_number(input int unsigned d,
                                                     input int unsigned m,
                                                     input int unsigned y);
    int unsigned a, yy, mm;
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 + 1721119;
  endfunction

  // zeller's rule, monday = 1 .. sunday = 7
  function automatic int unsigned weekday_of(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned tm, ty, k, j, h;
    tm = m;
    ty = y;
    if (tm < 3) begin
      tm += 12;
      ty -= 1;
    end
    k = ty % 100;
    j = ty / 100;
    h = (d + 13 * (tm + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 5) % 7 + 1;
  endfunction

  function automatic gdn_res_t convert_request(input gdn_req_t r);
    gdn_res_t    res;
    longint unsigned a, b, c, dd, e, mm;
    int unsigned d, m, y, jd;
    logic        ok;
    if (gdn_action_e'(r.action) == DATE_TO_NUMBER) begin
      d  = r.day;
      m  = r.month;
      y  = r.year;
      ok = y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= days_in_month(m, y);
      if (!ok) begin
        d = 1;
        m = 1;
        y = 2000;
      end
      jd = date_to_day_number(d, m, y);
    end else begin
      jd = r.day_number;
      ok = 1'b1;
      if (jd < JDN_MIN) begin
        jd = JDN_MIN;
        ok = 1'b0;
      end else if (jd > JDN_MAX) begin
        jd = JDN_MAX;
        ok = 1'b0;
      end
      a  = jd + 32044;
      b  = (4 * a + 3) / 146097;
      c  = a - (146097 * b) / 4;
      dd = (4 * c + 3) / 1461;
      e  = c - (1461 * dd) / 4;
      mm = (5 * e + 2) / 153;
      d  = int'(e - (153 * mm + 2) / 5 + 1);
      m  = int'(mm + 3 - 12 * (mm / 10));
      y  = int'(100 * b + dd + mm / 10 - 4800);
    end
    res.day        = d[4:0];
    res.month      = m[3:0];
    res.year       = y[13:0];
    res.day_number = jd[22:0];
    res.weekday    = 3'(weekday_of(d, m, y));
    res.ok         = ok;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    gdn_req_t req;
    gdn_res_t got;
    gdn_res_t want;
    if (!rst_n) begin
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        req.action     = in_tuser;
        req.day        = in_tdata[4:0];
        req.month      = in_tdata[8:5];
        req.year       = in_tdata[22:9];
        req.day_number = in_tdata[45:23];
        expected_results.push_back(convert_request(req));
      end
      if (out_tvalid && out_tready) begin
        got.day        = out_tdata[4:0];
        got.month      = out_tdata[8:5];
        got.year       = out_tdata[22:9];
        got.day_number = out_tdata[45:23];
        got.weekday    = out_tdata[48:46];
        got.ok         = out_tuser;
        results_seen++;
        if (!got.ok) begin
          flagged_seen++;
        end
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_tdata %h out_tuser %b", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_day", want.day, got.day);
          check_field("out_month", want.month, got.month);
          check_field("out_year", want.year, got.year);
          check_field("out_day_number", want.day_number, got.day_number);
          check_field("weekday", want.weekday, got.weekday);
          check_field("valid_res", want.ok, got.ok);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: verif/tb_gregorian_day_number_converter.sv
`timescale 1ns / 1ps

module tb_gregorian_day_number_converter;
  import gdn_pkg::*;
  import gdn_tb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;

  bit steady_run = 1'b0;
  int mismatches;
  int outstanding;
  int results_seen;
  int flagged_seen;
  int cycles = 0;
  int date_reqs = 0;
  int number_reqs = 0;

  always #10 clk = ~clk;

  gregorian_day_number_converter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gdn_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .flagged_seen (flagged_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (steady_run) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 38);
    end
  end

  function automatic gdn_req_t date_req(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
    gdn_req_t r;
    r.action     = DATE_TO_NUMBER;
    r.day        = d[4:0];
    r.month      = m[3:0];
    r.year       = y[13:0];
    r.day_number = 23'($urandom);
    return r;
  endfunction

  function automatic gdn_req_t number_req(input int unsigned jd);
    gdn_req_t r;
    r.action     = NUMBER_TO_DATE;
    r.day        = 5'($urandom);
    r.month      = 4'($urandom);
    r.year       = 14'($urandom);
    r.day_number = jd[22:0];
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input gdn_req_t r);
    while (!steady_run && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= {2'b00, r.day_number, r.year, r.month, r.day};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (gdn_action_e'(r.action) == DATE_TO_NUMBER) begin
      date_reqs++;
    end else begin
      number_reqs++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  initial begin
    int unsigned kind;
    int unsigned d, m, y;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_request(date_req(1, 1, 1));
    send_request(date_req(31, 12, 9999));
    send_request(date_req(1, 1, 2000));
    send_request(date_req(29, 2, 2000));
    send_request(date_req(29, 2, 1900));
    send_request(date_req(29, 2, 2004));
    send_request(date_req(29, 2, 2001));
    send_request(date_req(28, 2, 1900));
    send_request(date_req(1, 3, 1600));
    send_request(date_req(31, 4, 2023));
    send_request(date_req(0, 6, 2020));
    send_request(date_req(31, 1, 1));
    send_request(date_req(15, 0, 1999));
    send_request(date_req(15, 13, 1999));
    send_request(date_req(31, 15, 16383));
    send_request(date_req(1, 1, 0));
    send_request(date_req(1, 1, 10000));
    send_request(date_req(0, 0, 0));
    send_request(number_req(JDN_MIN));
    send_request(number_req(JDN_MIN - 1));
    send_request(number_req(0));
    send_request(number_req(JDN_MAX));
    send_request(number_req(JDN_MAX + 1));
    send_request(number_req(23'h7fffff));
    send_request(number_req(2451545));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_run <= (i >= 200 && i < 350);
      if (i == 420) begin
        wait_drained();
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        case ($urandom_range(9))
          0:       y = $urandom_range(30, 1);
          1:       y = $urandom_range(9999, 9970);
          2:       y = $urandom_range(99, 1) * 100;
          default: y = $urandom_range(9999, 1);
        endcase
        m = $urandom_range(12, 1);
        d = ($urandom_range(3) == 0) ? days_in_month(m, y)
                                     : $urandom_range(days_in_month(m, y), 1);
        send_request(date_req(d, m, y));
      end else if (kind < 55) begin
        send_request(date_req($urandom_range(31), $urandom_range(15), $urandom_range(16383)));
      end else if (kind < 88) begin
        send_request(number_req($urandom_range(JDN_MAX, JDN_MIN)));
      end else if (kind < 94) begin
        send_request(number_req($urandom_range(JDN_MIN - 1, 0)));
      end else begin
        send_request(number_req($urandom_range(23'h7fffff, JDN_MAX + 1)));
      end
    end
    in_tvalid <= 1'b0;
    steady_run <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d date requests and %0d day number requests", date_reqs, number_reqs);
    $display("checked %0d results, %0d of them flagged invalid or clamped",
             results_seen, flagged_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
